// ===== hdl/icd_pkg.sv =====
// Package for the input change event debouncer.
// Holds the request structs, the configuration struct and register codes.
// No dependencies.
package icd_pkg;

    localparam int SAMPLE_W = 12;
    localparam int LOCK_W   = 8;
    localparam int CHAN_W   = 4;
    localparam int CFG_W    = 12;
    localparam int INDEX_W  = 2;

    localparam logic [INDEX_W-1:0] REG_LOCKOUT_TIME = 2'd0;
    localparam logic [INDEX_W-1:0] REG_ENABLE_MASK  = 2'd1;

    localparam logic [LOCK_W-1:0]   LOCKOUT_TIME_RST = 8'd20;
    localparam logic [SAMPLE_W-1:0] ENABLE_MASK_RST  = 12'h80F;

    typedef struct packed {
        logic [SAMPLE_W-1:0] pin_sample;
        logic                ms_tick;
    } in_t;

    typedef struct packed {
        logic [CHAN_W-1:0] channel;
        logic              new_level;
        logic              last_event;
    } out_t;

    typedef struct packed {
        logic [LOCK_W-1:0]   lockout_time;
        logic [SAMPLE_W-1:0] lockout_enable_mask;
    } cfg_t;

endpackage

// ===== hdl/icd_fifo.sv =====
// Short request queue between the front and back parts.
// Register array with count; depends on nothing outside this file.
module icd_fifo #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/icd_front.sv =====
// Front part: accepts requests, runs the lockout counters and stored levels,
// and forms the mask of channels that fire. Uses icd_pkg.
module icd_front #(
    parameter int CHANNELS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  icd_pkg::in_t          in_data,
    input  icd_pkg::cfg_t         cfg,
    output logic                  push,
    output logic [CHANNELS-1:0]   fire_mask,
    output logic [CHANNELS-1:0]   sample_bits
);
    import icd_pkg::*;

    logic [CHANNELS-1:0]        levels_reg, levels_next;
    logic                       primed_reg;
    logic [LOCK_W-1:0]          cnt_reg  [CHANNELS];
    logic [LOCK_W-1:0]          cnt_next [CHANNELS];
    logic [LOCK_W-1:0]          cnt_dec  [CHANNELS];
    logic [CHANNELS+SAMPLE_W-1:0] sample_ext, enable_ext;
    logic [CHANNELS-1:0]        sample, enable, change;

    assign sample_ext  = {{CHANNELS{1'b0}}, in_data.pin_sample};
    assign enable_ext  = {{CHANNELS{1'b0}}, cfg.lockout_enable_mask};
    assign sample      = sample_ext[CHANNELS-1:0];
    assign enable      = enable_ext[CHANNELS-1:0];
    assign change      = sample ^ levels_reg;
    assign sample_bits = sample;

    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            cnt_dec[i] = (in_data.ms_tick && cnt_reg[i] != '0) ? cnt_reg[i] - 1'b1
                                                                  : cnt_reg[i];
            fire_mask[i] = primed_reg && change[i] && (cnt_dec[i] == '0);
            cnt_next[i]  = (fire_mask[i] && enable[i]) ? cfg.lockout_time : cnt_dec[i];
        end
        push        = accept && (fire_mask != '0);
        levels_next = (!primed_reg || fire_mask != '0) ? sample : levels_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg <= '0;
            primed_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            levels_reg <= levels_next;
            primed_reg <= 1'b1;
            for (int i = 0; i < CHANNELS; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

endmodule

// ===== hdl/icd_back.sv =====
// Back part: takes queued fire masks, issues one event per cycle unless
// out_stall holds it, in channel order via out_data_reg. Uses icd_pkg.
module icd_back #(
    parameter int CHANNELS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    input  logic [2*CHANNELS-1:0] q_data,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output icd_pkg::out_t         out_data
);
    import icd_pkg::*;

    logic [CHANNELS-1:0] mask_reg, mask_next;
    logic [CHANNELS-1:0] levels_reg, levels_next;
    logic                out_valid_reg, out_valid_next;
    out_t                out_data_reg, out_data_next;
    logic [CHANNELS-1:0] lowest, rest;
    logic [CHAN_W-1:0]   chan;
    logic                out_free, emit, last;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        lowest = mask_reg & (~mask_reg + 1'b1);
        rest   = mask_reg & ~lowest;
        last   = (rest == '0);
        chan   = '0;
        for (int i = CHANNELS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                chan = CHAN_W'(i);
            end
        end

        out_free = !out_valid_reg || !out_stall;
        emit     = out_free && (mask_reg != '0);
        q_pop    = !q_empty && ((mask_reg == '0) || (emit && last));

        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        mask_next      = mask_reg;
        levels_next    = levels_reg;
        if (emit)
        begin
            out_valid_next           = 1'b1;
            out_data_next.channel    = chan;
            out_data_next.new_level  = |(lowest & levels_reg);
            out_data_next.last_event = last;
            mask_next                = rest;
        end
        if (q_pop)
        begin
            mask_next   = q_data[2*CHANNELS-1:CHANNELS];
            levels_next = q_data[CHANNELS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        levels_reg   <= levels_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ===== hdl/input_change_event_debouncer.sv =====
// Top level of the input change event debouncer: configuration registers,
// front part, request queue and back part. Uses icd_pkg, icd_front,
// icd_fifo and icd_back.
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid, in_stall, in_data      | sample in
//  out     | out_valid, out_stall, out_data   | event out
//  cfg     | cfg_write, cfg_index, cfg_data   | write only
//
// An input request is taken every cycle while the queue has room; it updates
// the counters at once and queues its fire mask if any channel fires. The back
// part issues one event per cycle while out_stall is low, so an item's events
// leave one after another, and items without events cost no output time.
// Reset clears the control state and loads the register defaults; no clearing pass.
// in_stall rises while QUEUE_DEPTH masks wait, under output stalls or event bursts.
module input_change_event_debouncer #(
    parameter int CHANNELS    = 12,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  icd_pkg::in_t                    in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output icd_pkg::out_t                   out_data,
    input  logic                            cfg_write,
    input  logic [icd_pkg::INDEX_W-1:0]     cfg_index,
    input  logic [icd_pkg::CFG_W-1:0]       cfg_data
);
    import icd_pkg::*;

    cfg_t                  cfg_reg, cfg_next;
    logic                  accept, push, pop, full, empty;
    logic [CHANNELS-1:0]   fire_mask, sample_bits;
    logic [2*CHANNELS-1:0] q_data;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_LOCKOUT_TIME: cfg_next.lockout_time        = cfg_data[LOCK_W-1:0];
                REG_ENABLE_MASK:  cfg_next.lockout_enable_mask = cfg_data[SAMPLE_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lockout_time        <= LOCKOUT_TIME_RST;
            cfg_reg.lockout_enable_mask <= ENABLE_MASK_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    icd_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .in_data     (in_data),
        .cfg         (cfg_reg),
        .push        (push),
        .fire_mask   (fire_mask),
        .sample_bits (sample_bits)
    );

    icd_fifo #(
        .WIDTH (2 * CHANNELS),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({fire_mask, sample_bits}),
        .full      (full),
        .pop       (pop),
        .pop_data  (q_data),
        .empty     (empty)
    );

    icd_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (empty),
        .q_data    (q_data),
        .q_pop     (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== dv/tb_input_change_event_debouncer.sv =====
// Self-checking testbench for input_change_event_debouncer.
// Predicts the channel events of each accepted sample request and checks them
// in order; depends on icd_pkg and the RTL under hdl only.
`timescale 1ns / 100ps

module tb_input_change_event_debouncer;
    import icd_pkg::*;

    localparam logic [INDEX_W-1:0] REG_UNUSED_A = 2'd2;
    localparam logic [INDEX_W-1:0] REG_UNUSED_B = 2'd3;
    localparam int DRAIN_CYCLES = 8;

    class edge_predictor;
        logic [LOCK_W-1:0]   lock_time;
        logic [SAMPLE_W-1:0] lock_enable;
        logic [SAMPLE_W-1:0] levels;
        bit                  primed;
        logic [LOCK_W-1:0]   lock_count [SAMPLE_W];
        out_t                pending_events [$];
        int                  errors;
        int                  events_seen;
        int                  samples_seen;

        function new();
            lock_time    = LOCKOUT_TIME_RST;
            lock_enable  = ENABLE_MASK_RST;
            levels       = '0;
            primed       = 1'b0;
            errors       = 0;
            events_seen  = 0;
            samples_seen = 0;
            foreach (lock_count[i])
                lock_count[i] = '0;
        endfunction

        function void write_reg(logic [INDEX_W-1:0] index, logic [CFG_W-1:0] data);
            if (index == REG_LOCKOUT_TIME)
                lock_time = data[LOCK_W-1:0];
            else if (index == REG_ENABLE_MASK)
                lock_enable = data[SAMPLE_W-1:0];
        endfunction

        function int pending();
            return pending_events.size();
        endfunction

        function void note_sample(in_t req);
            logic [SAMPLE_W-1:0] change;
            out_t                burst [$];
            out_t                ev;
            samples_seen++;
            if (req.ms_tick)
                foreach (lock_count[i])
                    if (lock_count[i] != '0)
                        lock_count[i] = lock_count[i] - 1'b1;
            if (!primed)
            begin
                levels = req.pin_sample;
                primed = 1'b1;
                return;
            end
            change = req.pin_sample ^ levels;
            for (int i = 0; i < SAMPLE_W; i++)
            begin
                if (change[i] && lock_count[i] == '0)
                begin
                    ev.channel    = CHAN_W'(i);
                    ev.new_level  = req.pin_sample[i];
                    ev.last_event = 1'b0;
                    burst = {burst, ev};
                    if (lock_enable[i])
                        lock_count[i] = lock_time;
                end
            end
            if (burst.size() > 0)
            begin
                burst[burst.size() - 1].last_event = 1'b1;
                levels = req.pin_sample;
                foreach (burst[k])
                    pending_events = {pending_events, burst[k]};
            end
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        task check_event(out_t got);
            out_t want;
            events_seen++;
            if (pending_events.size() == 0)
            begin
                report_mismatch($sformatf("event on channel %0d with none pending",
                                          got.channel));
                return;
            end
            want = pending_events.pop_front();
            if (got.channel !== want.channel)
                report_mismatch($sformatf("channel %0d, want %0d", got.channel, want.channel));
            if (got.new_level !== want.new_level)
                report_mismatch($sformatf("channel %0d new_level %0b, want %0b",
                                          want.channel, got.new_level, want.new_level));
            if (got.last_event !== want.last_event)
                report_mismatch($sformatf("channel %0d last_event %0b, want %0b",
                                          want.channel, got.last_event, want.last_event));
        endtask
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    in_t                 in_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    out_t                out_data;
    logic                cfg_write = 1'b0;
    logic [INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]    cfg_data = '0;

    edge_predictor       predictor = new();
    logic [SAMPLE_W-1:0] last_sample = '0;
    int                  settings_used = 0;
    int                  stall_style = 0;
    int                  style_left = 0;
    int                  stall_hold = 0;

    input_change_event_debouncer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write)
                predictor.write_reg(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                predictor.note_sample(in_data);
            if (out_valid && !out_stall)
                predictor.check_event(out_data);
        end
    end

    // receiver: free-running, stall pattern changes in windows
    always @(negedge clk)
    begin
        if (style_left == 0)
        begin
            stall_style = $urandom_range(0, 3);
            style_left  = $urandom_range(50, 300);
        end
        else
            style_left--;
        if (stall_hold != 0)
            stall_hold--;
        else
        begin
            case (stall_style)
                0: out_stall = 1'b0;
                1: out_stall = ($urandom_range(0, 3) == 0);
                2: out_stall = ($urandom_range(0, 3) != 0);
                default:
                begin
                    out_stall  = !out_stall;
                    stall_hold = out_stall ? $urandom_range(0, 15) : $urandom_range(0, 6);
                end
            endcase
        end
    end

    function automatic in_t make_req(logic [SAMPLE_W-1:0] sample, logic tick);
        in_t req;
        req.pin_sample = sample;
        req.ms_tick    = tick;
        return req;
    endfunction

    task automatic send_sample(in_t req);
        @(negedge clk);
        in_valid    = 1'b1;
        in_data     = req;
        last_sample = req.pin_sample;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic idle_sender(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
    endtask

    task automatic write_reg(logic [INDEX_W-1:0] index, logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic set_lockout(logic [CFG_W-1:0] lock_data, logic [CFG_W-1:0] mask_data);
        write_reg(REG_LOCKOUT_TIME, lock_data);
        write_reg(REG_ENABLE_MASK, mask_data);
        settings_used++;
    endtask

    // hold the sender until every predicted event has come out
    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (predictor.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic run_phase(int count, int tick_pct);
        int                  burst_left;
        in_t                 req;
        logic [SAMPLE_W-1:0] flips;
        burst_left = $urandom_range(1, 24);
        for (int k = 0; k < count; k++)
        begin
            req.ms_tick = ($urandom_range(0, 99) < tick_pct);
            case ($urandom_range(0, 9))
                0:       req.pin_sample = SAMPLE_W'($urandom);
                1, 2:    req.pin_sample = last_sample;
                3:       req.pin_sample = last_sample ^ SAMPLE_W'($urandom);
                default:
                begin
                    flips = '0;
                    flips[$urandom_range(0, SAMPLE_W - 1)] = 1'b1;
                    if ($urandom_range(0, 2) == 0)
                        flips[$urandom_range(0, SAMPLE_W - 1)] = 1'b1;
                    req.pin_sample = last_sample ^ flips;
                end
            endcase
            send_sample(req);
            burst_left--;
            if (burst_left == 0)
            begin
                idle_sender($urandom_range(1, 10));
                burst_left = ($urandom_range(0, 3) == 0) ? 80 : $urandom_range(1, 24);
            end
        end
    endtask

    initial
    begin
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // register defaults: priming, all channels at once, lost and held changes
        send_sample(make_req(12'hFFF, 1'b1));
        send_sample(make_req(12'h000, 1'b0));
        send_sample(make_req(12'hFFF, 1'b0));
        send_sample(make_req(12'hFFF, 1'b0));
        send_sample(make_req(12'hFFE, 1'b1));
        send_sample(make_req(12'h7FE, 1'b0));
        send_sample(make_req(12'h800, 1'b1));
        settings_used++;
        run_phase(50, 30);
        wait_drained();

        // zero lockout with high data bits set; unknown indexes must be ignored
        set_lockout(12'hF00, 12'hFFF);
        write_reg(REG_UNUSED_A, 12'hABC);
        write_reg(REG_UNUSED_B, 12'h123);
        repeat (20)
            send_sample(make_req(last_sample, 1'b1));
        send_sample(make_req(12'h000, 1'b0));
        send_sample(make_req(12'hFFF, 1'b0));
        send_sample(make_req(12'h000, 1'b0));
        send_sample(make_req(12'hA5A, 1'b0));
        run_phase(40, 50);
        wait_drained();

        set_lockout(12'h0FF, 12'h000);
        run_phase(40, 50);
        wait_drained();

        set_lockout(12'h0FF, 12'hFFF);
        run_phase(50, 95);
        wait_drained();

        repeat (3)
        begin
            set_lockout(CFG_W'($urandom_range(1, 8)), CFG_W'($urandom));
            run_phase(40, $urandom_range(20, 80));
            wait_drained();
        end

        $display("covered %0d sample requests and %0d events over %0d lockout settings",
                 predictor.samples_seen, predictor.events_seen, settings_used);
        $display("%0d mismatches reported", predictor.errors);
        if (predictor.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("timeout with %0d events still pending", predictor.pending());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/icd_pkg.sv
hdl/icd_fifo.sv
hdl/icd_front.sv
hdl/icd_back.sv
hdl/input_change_event_debouncer.sv
dv/tb_input_change_event_debouncer.sv
